/* rtl/ese_pkg.sv */
// ----------------------------------------------------------------------------
// Encoder speed estimator package
// Shared widths, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package ese_pkg;

  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned SPEED_BITS_DEF = 24;

  localparam int unsigned PULSE_W   = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned DIV_W     = 8;

  // speed = pulses * 1e6 * 2^FRAC_BITS / (elapsed * divisor)
  localparam int unsigned US_PER_S  = 1000000;
  localparam int unsigned US_W      = 20;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned PROD_W    = PULSE_W + US_W;
  localparam int unsigned QUO_W     = PROD_W + FRAC_BITS;

  localparam logic [31:0]      WINDOW_US_RST  = 32'd50000;
  localparam logic [31:0]      STOP_US_RST    = 32'd200000;
  localparam logic [DIV_W-1:0] DIVISOR_RST    = 8'd24;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_US = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_US   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR   = 8'd3;

  typedef enum logic {
    OP_PULSE = 1'b0,
    OP_POLL  = 1'b1
  } ese_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } ese_state_e;

  typedef struct packed {
    logic load_item;
    logic eval;
    logic mul;
    logic div_step;
    logic fin;
    logic out_load;
  } ese_cmd_t;

  typedef struct packed {
    logic need_speed;
    logic out_free;
  } ese_sts_t;

endpackage

`default_nettype wire

/* rtl/ese_ifs.sv */
// ----------------------------------------------------------------------------
// Encoder speed estimator channels
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ese_in_if
  import ese_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [TIME_BITS-1:0] time_us;

  modport source (output valid, opcode, time_us, input ready);
  modport sink   (input valid, opcode, time_us, output ready);
endinterface

interface ese_out_if
  import ese_pkg::*;
#(
  parameter int unsigned SPEED_BITS = SPEED_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PULSE_W-1:0]    pulse_total;
  logic [SPEED_BITS-1:0] speed_q8;
  logic                  moving;

  modport source (output valid, pulse_total, speed_q8, moving, input ready);
  modport sink   (input valid, pulse_total, speed_q8, moving, output ready);
endinterface

interface ese_cfg_if
  import ese_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/encoder_speed_estimator.sv */
// ----------------------------------------------------------------------------
// Encoder speed estimator
// Counts encoder pulses and measures speed over a time window (M method).
//
//   channel   dir  handshake            payload
//   item_i    in   valid / ready        opcode, time_us
//   result_o  out  valid / ready        pulse_total, speed_q8, moving
//   cfg_i     in   valid / ready (=1)   index, data
//
// A pulse that closes a window goes from accept to result valid through evaluate,
// multiply, 60 steps of the radix-2 divider, finish and load.
// Any other request goes through evaluate and load only.
// A new request is taken once the controller is idle, while the previous
// result may still wait in the output register.
// Reset clears window state and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_estimator
  import ese_pkg::*;
#(
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
  parameter int unsigned SPEED_BITS = SPEED_BITS_DEF
)(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ese_in_if.sink    item_i,
  ese_out_if.source result_o,
  ese_cfg_if.sink   cfg_i
);

  ese_cmd_t cmd;
  ese_sts_t sts;
  logic     in_ready;

  assign item_i.ready = in_ready;
  assign cfg_i.ready  = 1'b1;

  ese_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ese_dp #(
    .TIME_BITS  (TIME_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .opcode_i      (item_i.opcode),
    .time_us_i     (item_i.time_us),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .pulse_total_o (result_o.pulse_total),
    .speed_q8_o    (result_o.speed_q8),
    .moving_o      (result_o.moving)
  );

endmodule

`default_nettype wire

/* rtl/ese_ctrl.sv */
// ----------------------------------------------------------------------------
// Encoder speed estimator controller
// Sequences evaluate, multiply, serial divide and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_ctrl
  import ese_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ese_sts_t sts_i,
  output ese_cmd_t      cmd_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W);

  ese_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_speed ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        // hold until the result register can take the new result
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_load_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_item |=> state_q == ST_EVAL)
    else $error("item load not followed by evaluate");

  a_fin_after_all_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |-> cnt_q == CNT_W'(QUO_W - 1))
    else $error("divide finished before all quotient bits");

endmodule

`default_nettype wire

/* rtl/ese_dp.sv */
// ----------------------------------------------------------------------------
// Encoder speed estimator datapath
// Config registers, window state, speed multiply and radix-2 divider,
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ese_dp
  import ese_pkg::*;
#(
  parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
  parameter int unsigned SPEED_BITS = SPEED_BITS_DEF
)(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ese_cmd_t              cmd_i,
  output ese_sts_t                   sts_o,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data_i,
  input  wire logic                  opcode_i,
  input  wire logic [TIME_BITS-1:0]  time_us_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [PULSE_W-1:0]         pulse_total_o,
  output logic [SPEED_BITS-1:0]      speed_q8_o,
  output logic                       moving_o
);

  localparam int unsigned CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int unsigned DW    = TIME_BITS + DIV_W;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

  // configuration
  logic             enable_q;
  logic [31:0]      window_us_q;
  logic [31:0]      stop_us_q;
  logic [DIV_W-1:0] divisor_q;

  // window state
  logic [PULSE_W-1:0]    pulse_cnt_q;
  logic [PULSE_W-1:0]    wsc_q;
  logic [TIME_BITS-1:0]  wst_q;
  logic                  active_q;
  logic [SPEED_BITS-1:0] speed_q;

  // item and arithmetic
  logic                 op_q;
  logic [TIME_BITS-1:0] time_q;
  logic [PULSE_W-1:0]   delta_q;
  logic [TIME_BITS-1:0] elapsed_q;
  logic [QUO_W-1:0]     nq_q, nq_d;
  logic [DW-1:0]        d_q, d_d;
  logic [DW-1:0]        rem_q, rem_d;

  logic                  out_valid_q;
  logic [PULSE_W-1:0]    out_pulse_q;
  logic [SPEED_BITS-1:0] out_speed_q;
  logic                  out_moving_q;

  logic [PULSE_W-1:0]    pulse_inc;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  win_over;
  logic                  stop_over;
  logic [DIV_W-1:0]      div_eff;
  logic [PROD_W-1:0]     prod;
  logic [DW:0]           rem_sh;
  logic                  q_bit;
  logic [SPEED_BITS-1:0] speed_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      window_us_q <= WINDOW_US_RST;
      stop_us_q   <= STOP_US_RST;
      divisor_q   <= DIVISOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE:    enable_q    <= cfg_data_i[0];
        CFG_WINDOW_US: window_us_q <= cfg_data_i[31:0];
        CFG_STOP_US:   stop_us_q   <= cfg_data_i[31:0];
        CFG_DIVISOR:   divisor_q   <= cfg_data_i[DIV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pulse_inc = pulse_cnt_q + 1'b1;
  assign elapsed   = time_q - wst_q;
  assign win_over  = CMP_W'(elapsed) > CMP_W'(window_us_q);
  assign stop_over = CMP_W'(elapsed) > CMP_W'(stop_us_q);

  assign sts_o.need_speed = (op_q == OP_PULSE) && active_q && win_over;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_cnt_q <= '0;
      wsc_q       <= '0;
      wst_q       <= '0;
      active_q    <= 1'b0;
      speed_q     <= '0;
    end else begin
      if (cmd_i.eval) begin
        if (op_q == OP_PULSE) begin
          pulse_cnt_q <= pulse_inc;
          if (!active_q) begin
            wsc_q    <= pulse_inc;
            wst_q    <= time_q;
            active_q <= 1'b1;
          end else if (win_over) begin
            // restart the window at this pulse
            wsc_q <= pulse_inc;
            wst_q <= time_q;
          end
        end else if (enable_q && active_q && stop_over) begin
          active_q <= 1'b0;
        end
      end
      if (cmd_i.fin) begin
        speed_q <= speed_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= opcode_i;
      time_q <= time_us_i;
    end
    if (cmd_i.eval) begin
      delta_q   <= pulse_inc - wsc_q;
      elapsed_q <= elapsed;
    end
    if (cmd_i.mul || cmd_i.div_step) begin
      nq_q  <= nq_d;
      d_q   <= d_d;
      rem_q <= rem_d;
    end
  end

  assign div_eff = (divisor_q == '0) ? DIV_W'(1) : divisor_q;
  assign prod    = PROD_W'(delta_q) * PROD_W'(US_PER_S);
  assign rem_sh  = {rem_q, nq_q[QUO_W-1]};
  assign q_bit   = rem_sh >= {1'b0, d_q};

  // shift the numerator out the top, quotient bits in at the bottom
  always_comb begin
    nq_d  = nq_q;
    d_d   = d_q;
    rem_d = rem_q;
    if (cmd_i.mul) begin
      nq_d  = {prod, FRAC_BITS'(0)};
      d_d   = DW'(elapsed_q) * DW'(div_eff);
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      nq_d  = {nq_q[QUO_W-2:0], q_bit};
      rem_d = q_bit ? DW'(rem_sh - {1'b0, d_q}) : DW'(rem_sh);
    end
  end

  assign speed_sat = (|nq_q[QUO_W-1:SPEED_BITS]) ? SPEED_MAX : nq_q[SPEED_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pulse_q  <= pulse_cnt_q;
      out_speed_q  <= (enable_q && active_q) ? speed_q : '0;
      out_moving_q <= active_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_total_o = out_pulse_q;
  assign speed_q8_o    = out_speed_q;
  assign moving_o      = out_moving_q;

  a_pulse_counts_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && op_q == OP_PULSE) |=> pulse_cnt_q == $past(pulse_cnt_q) + 1'b1)
    else $error("pulse count did not advance by one");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < d_q)
    else $error("divider remainder not below divisor");

  a_speed_only_on_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.fin |=> $stable(speed_q))
    else $error("stored speed changed outside divide finish");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder speed estimator testbench
// Drives timestamped pulse and poll requests with random gaps and output
// stalls. A scoreboard predicts pulse count, windowed speed and the moving
// flag, and checks every result in order. The run steps through several
// register settings, the extremes among them.
// ----------------------------------------------------------------------------

module tb;
  import ese_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    bit [31:0] total;
    bit [23:0] speed;
    bit        moving;
  } speed_rpt_t;

  class speed_scoreboard;
    bit        en;
    bit [31:0] win;
    bit [31:0] stop;
    bit [7:0]  div;
    bit [31:0] pulses;
    bit [31:0] start_pulses;
    bit [31:0] start_time;
    bit        active;
    bit [23:0] speed;
    speed_rpt_t due_reports[$];
    int errors;

    function new();
      en = 1'b1;
      win = WINDOW_US_RST;
      stop = STOP_US_RST;
      div = DIVISOR_RST;
      pulses = '0;
      start_pulses = '0;
      start_time = '0;
      active = 1'b0;
      speed = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
      case (idx)
        CFG_ENABLE: en = data[0];
        CFG_WINDOW_US: win = data;
        CFG_STOP_US: stop = data;
        CFG_DIVISOR: div = data[7:0];
        default: ;
      endcase
    endfunction

    function bit [23:0] window_speed(bit [31:0] n, bit [31:0] el);
      longint unsigned q;
      longint unsigned d;
      d = (div == 0) ? 1 : longint'(div);
      if (el == 0) return '1;
      q = (64'(n) * 64'd256000000) / 64'(el);
      q = q / d;
      if (q > 64'hFF_FFFF) return '1;
      return q[23:0];
    endfunction

    function void note_item(ese_op_e op, bit [31:0] t);
      bit [31:0] el;
      speed_rpt_t r;
      el = t - start_time;
      if (op == OP_PULSE) begin
        pulses = pulses + 1;
        if (!active) begin
          start_pulses = pulses;
          start_time = t;
          active = 1'b1;
        end else if (el > win) begin
          speed = window_speed(pulses - start_pulses, el);
          start_pulses = pulses;
          start_time = t;
        end
      end else if (en && active && el > stop) begin
        active = 1'b0;
      end
      r.total = pulses;
      r.speed = (en && active) ? speed : '0;
      r.moving = active;
      due_reports.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t MISMATCH %s", $time, msg);
    endtask

    task check_result(bit [31:0] tot, bit [23:0] spd, bit mov);
      speed_rpt_t want;
      if (due_reports.size() == 0) begin
        report($sformatf("result with nothing outstanding: total=%0d speed=%0d moving=%0d",
                         tot, spd, mov));
        return;
      end
      want = due_reports.pop_front();
      if (tot != want.total)
        report($sformatf("pulse_total got %0d want %0d", tot, want.total));
      if (spd != want.speed)
        report($sformatf("speed_q8 got %0d want %0d", spd, want.speed));
      if (mov != want.moving)
        report($sformatf("moving got %0d want %0d", mov, want.moving));
    endtask

    task flush();
      while (due_reports.size() != 0) begin
        report($sformatf("result never arrived: total=%0d", due_reports[0].total));
        void'(due_reports.pop_front());
      end
    endtask

    function int pending();
      return due_reports.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ese_in_if  #(.TIME_BITS(32))  item_ch ();
  ese_out_if #(.SPEED_BITS(24)) res_ch ();
  ese_cfg_if                    cfg_ch ();

  encoder_speed_estimator u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (res_ch),
    .cfg_i    (cfg_ch)
  );

  speed_scoreboard speed_sb;
  bit [31:0] now_us;
  int in_gap_max;
  int out_stall_max;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // Abort when the channels stop moving.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  task automatic send_item(ese_op_e op, bit [31:0] t);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= op;
    item_ch.time_us <= t;
    do @(posedge clk_i); while (!item_ch.ready);
    speed_sb.note_item(op, t);
  endtask

  // Drop valid and wait until every outstanding result is back.
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (speed_sb.pending() != 0);
  endtask

  task automatic program_regs(bit en, bit [31:0] win, bit [31:0] stop, bit [7:0] div);
    logic [CFG_IDX_W-1:0] idx[4];
    bit [31:0] val[4];
    idx[0] = CFG_ENABLE;
    idx[1] = CFG_WINDOW_US;
    idx[2] = CFG_STOP_US;
    idx[3] = CFG_DIVISOR;
    val[0] = 32'(en);
    val[1] = win;
    val[2] = stop;
    val[3] = 32'(div);
    for (int k = 0; k < 4; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data <= val[k];
      do @(posedge clk_i); while (!cfg_ch.ready);
      speed_sb.set_reg(idx[k], val[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly pulse trains and polls on a running clock, plus requests placed
  // right at the window and timeout boundaries and some scattered timestamps.
  task automatic run_random(int count, bit [31:0] scale);
    int r;
    ese_op_e op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      op = OP_PULSE;
      if (r < 58) begin
        now_us += $urandom_range(0, scale);
      end else if (r < 78) begin
        op = OP_POLL;
        now_us += $urandom_range(0, scale);
      end else if (r < 87) begin
        op = OP_POLL;
        now_us = speed_sb.start_time + speed_sb.stop + $urandom_range(0, 2);
      end else if (r < 94) begin
        now_us = speed_sb.start_time + speed_sb.win + $urandom_range(0, 1);
      end else if (r < 97) begin
        op = ese_op_e'($urandom_range(0, 1));
        now_us = $urandom;
      end
      // otherwise repeat the last timestamp
      send_item(op, now_us);
    end
  endtask

  // Result sink: random stall before taking each result.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      speed_sb.check_result(res_ch.pulse_total, res_ch.speed_q8, res_ch.moving);
    end
  end

  initial begin
    speed_sb = new();
    idle_cycles = 0;
    in_gap_max = 12;
    out_stall_max = 12;
    now_us = '0;
    rst_ni <= 1'b0;
    item_ch.valid <= 1'b0;
    item_ch.opcode <= OP_PULSE;
    item_ch.time_us <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_ENABLE;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero timestamp, window and timeout boundaries, wrap.
    send_item(OP_POLL, 32'd0);
    send_item(OP_PULSE, 32'd0);
    send_item(OP_PULSE, 32'd50000);
    send_item(OP_PULSE, 32'd50001);
    send_item(OP_POLL, 32'd250001);
    send_item(OP_POLL, 32'd250002);
    send_item(OP_PULSE, 32'd250010);
    send_item(OP_PULSE, 32'hFFFF_FFFF);
    send_item(OP_PULSE, 32'd1000);
    send_item(OP_PULSE, 32'd60000);
    send_item(OP_POLL, 32'hFFFF_FFF0);
    now_us = 32'hFFFF_FFF0;
    run_random(250, 32'd5000);
    drain();

    // Disabled encoder: speed reads zero and polls never stop the wheel.
    program_regs(1'b0, 32'd1000, 32'd5000, 8'd255);
    send_item(OP_PULSE, now_us + 32'd10);
    send_item(OP_POLL, now_us + 32'd100000);
    now_us += 32'd100100;
    send_item(OP_PULSE, now_us);
    run_random(200, 32'd300);
    drain();

    // One-microsecond window and divisor of one: saturated speed.
    program_regs(1'b1, 32'd1, 32'd3, 8'd1);
    send_item(OP_PULSE, now_us + 32'd5);
    send_item(OP_PULSE, now_us + 32'd7);
    now_us += 32'd100;
    send_item(OP_POLL, now_us);
    run_random(200, 32'd2);
    drain();

    // Zero window length and zero divisor.
    program_regs(1'b1, 32'd0, 32'd1, 8'd0);
    send_item(OP_PULSE, now_us + 32'd3);
    now_us += 32'd4;
    send_item(OP_PULSE, now_us);
    run_random(150, 32'd2);
    drain();

    // Largest window and timeout.
    program_regs(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd200);
    run_random(150, 32'h0010_0000);
    drain();

    // Back to back, no idling on either side.
    in_gap_max = 0;
    out_stall_max = 0;
    program_regs(1'b1, 32'd10000, 32'd40000, 8'd4);
    run_random(250, 32'd1500);
    drain();

    in_gap_max = 12;
    out_stall_max = 12;
    program_regs(1'b1, 32'd200, 32'd1000, 8'd24);
    run_random(250, 32'd40);
    drain();

    program_regs(1'b1, WINDOW_US_RST, STOP_US_RST, DIVISOR_RST);
    run_random(200, 32'd5000);
    drain();

    in_gap_max = 3;
    program_regs(1'b0, 32'd500, 32'd2000, 8'd100);
    run_random(150, 32'd100);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    speed_sb.flush();
    if (speed_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
